FILE: hdl/pjh_pkg.sv
// Shared types and constants for the period jitter histogram.
package pjh_pkg;

    localparam int BINS_DEFAULT = 64;
    localparam int TIME_W = 32;
    localparam int JIT_W = 29;
    localparam int BIN_W = 6;
    localparam int COUNT_W = 32;
    localparam int ROUND_BIAS = 4;
    localparam int ROUND_SHIFT = 3;
    localparam logic [TIME_W-1:0] NOMINAL_RESET = 32'd80000;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [JIT_W-1:0] jitter;
        logic [BIN_W-1:0] bin;
        logic [JIT_W-1:0] max_jitter;
        logic             sel_ok;
    } pjh_res_t;

    typedef struct packed {
        logic [JIT_W-1:0]   jitter;
        logic [BIN_W-1:0]   bin;
        logic [JIT_W-1:0]   max_jitter;
        logic [COUNT_W-1:0] bin_count;
    } pjh_out_t;

endpackage

FILE: hdl/pjh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pjh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/pjh_front.sv
// Input register, interval deviation, rounding, bin clamp and running maximum.
module pjh_front #(
    parameter int BINS = pjh_pkg::BINS_DEFAULT,
    localparam int AW = $clog2(BINS)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [pjh_pkg::TIME_W-1:0]   nominal_period,
    input  logic                         clearing,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  pjh_pkg::op_t                 s_op,
    input  logic [pjh_pkg::TIME_W-1:0]   s_timestamp,
    input  logic [pjh_pkg::BIN_W-1:0]    s_bin_select,
    output logic                         s1_valid,
    input  logic                         s1_ready,
    output pjh_pkg::pjh_res_t            s1_res,
    output logic [AW-1:0]                s1_addr
);
    import pjh_pkg::*;

    localparam int XW = (AW > BIN_W) ? AW : BIN_W;

    logic              valid_reg, valid_next;
    op_t               op_reg;
    logic [TIME_W-1:0] ts_reg;
    logic [BIN_W-1:0]  sel_reg;
    logic [TIME_W-1:0] last_time_reg;
    logic [JIT_W-1:0]  peak_reg;

    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] dev;
    logic [TIME_W-1:0] rnd;
    logic [JIT_W-1:0]  jit;
    logic [JIT_W-1:0]  peak_new;
    logic [AW-1:0]     rec_addr;
    logic [XW-1:0]     bin_x;
    logic [XW-1:0]     sel_x;
    logic              advance;

    assign s_ready = !clearing && (!valid_reg || s1_ready);
    assign s1_valid = valid_reg;
    assign advance = valid_reg && s1_ready;

    always_comb begin
        diff = ts_reg - last_time_reg;
        if (diff > nominal_period) begin
            dev = diff - nominal_period;
        end else begin
            dev = nominal_period - diff;
        end
        rnd = dev + TIME_W'(ROUND_BIAS);
        jit = rnd[TIME_W-1:ROUND_SHIFT];
        peak_new = (jit > peak_reg) ? jit : peak_reg;
        if (32'(jit) >= 32'(BINS)) begin
            rec_addr = AW'(BINS - 1);
        end else begin
            rec_addr = jit[AW-1:0];
        end
        bin_x = XW'(rec_addr);
        sel_x = XW'(sel_reg);

        s1_res.op = op_reg;
        unique case (op_reg)
            OP_RECORD: begin
                s1_res.jitter = jit;
                s1_res.bin = bin_x[BIN_W-1:0];
                s1_res.max_jitter = peak_new;
                s1_res.sel_ok = 1'b0;
                s1_addr = rec_addr;
            end
            OP_READ: begin
                s1_res.jitter = '0;
                s1_res.bin = '0;
                s1_res.max_jitter = peak_reg;
                s1_res.sel_ok = 32'(sel_reg) < 32'(BINS);
                s1_addr = sel_x[AW-1:0];
            end
            default: begin
                s1_res.jitter = '0;
                s1_res.bin = '0;
                s1_res.max_jitter = peak_reg;
                s1_res.sel_ok = 1'b0;
                s1_addr = '0;
            end
        endcase
    end

    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (s1_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            last_time_reg <= '0;
            peak_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            if (advance && op_reg == OP_RECORD) begin
                last_time_reg <= ts_reg;
                peak_reg <= peak_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= s_op;
            ts_reg <= s_timestamp;
            sel_reg <= s_bin_select;
        end
    end

endmodule

FILE: hdl/pjh_hist.sv
// Histogram memory with clearing pass, read-modify-write, forwarding and result register.
module pjh_hist #(
    parameter int BINS = pjh_pkg::BINS_DEFAULT,
    localparam int AW = $clog2(BINS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    output logic              clearing,
    input  logic              s1_valid,
    output logic              s1_ready,
    input  pjh_pkg::pjh_res_t s1_res,
    input  logic [AW-1:0]     s1_addr,
    output logic              m_valid,
    input  logic              m_ready,
    output pjh_pkg::pjh_out_t m_out
);
    import pjh_pkg::*;

    logic               clr_active_reg;
    logic [AW-1:0]      clr_addr_reg;

    logic               s2_valid_reg, s2_valid_next;
    pjh_res_t           s2_res_reg;
    logic [AW-1:0]      s2_addr_reg;
    logic               fwd_hit_reg;
    logic [COUNT_W-1:0] fwd_data_reg;

    logic               m_valid_reg, m_valid_next;
    pjh_out_t           m_out_reg;

    logic               s2_move;
    logic               s1_move;
    logic               s2_rec;
    logic [COUNT_W-1:0] rdata;
    logic [COUNT_W-1:0] cur;
    logic [COUNT_W-1:0] inc;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [COUNT_W-1:0] wdata;

    assign clearing = clr_active_reg;
    assign s2_move = s2_valid_reg && (!m_valid_reg || m_ready);
    assign s1_ready = !clr_active_reg && (!s2_valid_reg || s2_move);
    assign s1_move = s1_valid && s1_ready;
    assign s2_rec = s2_res_reg.op == OP_RECORD;
    assign cur = fwd_hit_reg ? fwd_data_reg : rdata;
    assign inc = cur + COUNT_W'(1);

    always_comb begin
        if (clr_active_reg) begin
            we = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end else begin
            we = s2_move && s2_rec;
            waddr = s2_addr_reg;
            wdata = inc;
        end
    end

    pjh_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(BINS)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (s1_move),
        .raddr(s1_addr),
        .rdata(rdata)
    );

    always_comb begin
        if (s1_move) begin
            s2_valid_next = 1'b1;
        end else if (s2_move) begin
            s2_valid_next = 1'b0;
        end else begin
            s2_valid_next = s2_valid_reg;
        end
        if (s2_move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg <= '0;
            s2_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(BINS - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            s2_valid_reg <= s2_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // The item moving into the second stage reads the memory in the same cycle that the
    // item leaving it writes back, so a matching address takes the written count instead.
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            s2_res_reg <= s1_res;
            s2_addr_reg <= s1_addr;
            fwd_hit_reg <= s2_move && s2_rec && (s2_addr_reg == s1_addr);
            fwd_data_reg <= inc;
        end
        if (s2_move) begin
            m_out_reg.jitter <= s2_res_reg.jitter;
            m_out_reg.bin <= s2_res_reg.bin;
            m_out_reg.max_jitter <= s2_res_reg.max_jitter;
            if (!s2_rec && s2_res_reg.sel_ok) begin
                m_out_reg.bin_count <= cur;
            end else begin
                m_out_reg.bin_count <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out = m_out_reg;

endmodule

FILE: hdl/period_jitter_histogram.sv
// Top level of the period jitter histogram.
// Each record transaction measures the interval since the previous timestamp, rounds its
// deviation from nominal_period to units of eight ticks, tracks the maximum and counts
// it into a histogram bin; each read transaction returns one bin count. One transaction
// is accepted per clock cycle while the pipeline is not stalled by the output or by the
// clearing pass. Its result passes through the input register, the registered read of
// the histogram memory and the result register. After reset the block clears the
// memory, one bin a cycle, and accepts no transaction until that clearing pass ends.
module period_jitter_histogram #(
    parameter int BINS = pjh_pkg::BINS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,    // nominal_period
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,     // timestamp[31:0], bin_select[37:32], zero fill
    input  logic        s_tuser,     // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata      // jitter[28:0], bin[34:29], max_jitter[63:35],
                                     // bin_count[95:64]
);
    import pjh_pkg::*;

    localparam int AW = $clog2(BINS);

    logic [TIME_W-1:0] nominal_period_reg;
    logic              clearing;
    logic              s1_valid;
    logic              s1_ready;
    pjh_res_t          s1_res;
    logic [AW-1:0]     s1_addr;
    pjh_out_t          m_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nominal_period_reg <= NOMINAL_RESET;
        end else if (cfg_valid) begin
            nominal_period_reg <= cfg_data;
        end
    end

    pjh_front #(
        .BINS(BINS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .nominal_period(nominal_period_reg),
        .clearing      (clearing),
        .s_valid       (s_tvalid),
        .s_ready       (s_tready),
        .s_op          (op_t'(s_tuser)),
        .s_timestamp   (s_tdata[31:0]),
        .s_bin_select  (s_tdata[37:32]),
        .s1_valid      (s1_valid),
        .s1_ready      (s1_ready),
        .s1_res        (s1_res),
        .s1_addr       (s1_addr)
    );

    pjh_hist #(
        .BINS(BINS)
    ) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clearing(clearing),
        .s1_valid(s1_valid),
        .s1_ready(s1_ready),
        .s1_res  (s1_res),
        .s1_addr (s1_addr),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_out   (m_out)
    );

    assign m_tdata = {m_out.bin_count, m_out.max_jitter, m_out.bin, m_out.jitter};

endmodule

FILE: test/period_jitter_histogram_test.sv
// Self-checking stream testbench for the period jitter histogram, with an in-bench predictor.
module period_jitter_histogram_test;
    import pjh_pkg::*;

    localparam int BIN_COUNT = BINS_DEFAULT;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 155;
    localparam int DIRECTED_ROWS = 23;

    typedef struct packed {
        logic [COUNT_W-1:0] bin_count;
        logic [JIT_W-1:0]   max_jitter;
        logic [BIN_W-1:0]   bin;
        logic [JIT_W-1:0]   jitter;
    } hist_report_t;

    typedef enum logic [1:0] {
        ROW_RECORD,
        ROW_READ,
        ROW_PERIOD
    } row_kind_t;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SPARSE,
        FLOW_DENSE,
        FLOW_PATTERN
    } stall_style_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [31:0]        value;
        logic               typed;
        logic [JIT_W-1:0]   jitter;
        logic [BIN_W-1:0]   bin;
        logic [JIT_W-1:0]   max_jitter;
        logic [COUNT_W-1:0] bin_count;
    } step_row_t;

    step_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_READ,   32'd0,         1'b1, 29'd0,         6'd0,  29'd0,         32'd0},
        '{ROW_READ,   32'd63,        1'b1, 29'd0,         6'd0,  29'd0,         32'd0},
        '{ROW_RECORD, 32'd80000,     1'b1, 29'd0,         6'd0,  29'd0,         32'd0},
        '{ROW_RECORD, 32'd160003,    1'b1, 29'd0,         6'd0,  29'd0,         32'd0},
        '{ROW_RECORD, 32'd240007,    1'b1, 29'd1,         6'd1,  29'd1,         32'd0},
        '{ROW_RECORD, 32'd320003,    1'b1, 29'd1,         6'd1,  29'd1,         32'd0},
        '{ROW_RECORD, 32'd400507,    1'b1, 29'd63,        6'd63, 29'd63,        32'd0},
        '{ROW_RECORD, 32'd488507,    1'b1, 29'd1000,      6'd63, 29'd1000,      32'd0},
        '{ROW_READ,   32'd63,        1'b1, 29'd0,         6'd0,  29'd1000,      32'd2},
        '{ROW_READ,   32'd1,         1'b1, 29'd0,         6'd0,  29'd1000,      32'd2},
        '{ROW_READ,   32'd0,         1'b1, 29'd0,         6'd0,  29'd1000,      32'd2},
        '{ROW_READ,   32'd32,        1'b1, 29'd0,         6'd0,  29'd1000,      32'd0},
        '{ROW_RECORD, 32'd0,         1'b0, 29'd0,         6'd0,  29'd0,         32'd0},
        '{ROW_RECORD, 32'hFFFF_FFFF, 1'b0, 29'd0,         6'd0,  29'd0,         32'd0},
        '{ROW_PERIOD, 32'd0,         1'b0, 29'd0,         6'd0,  29'd0,         32'd0},
        '{ROW_RECORD, 32'hFFFF_FFFF, 1'b0, 29'd0,         6'd0,  29'd0,         32'd0},
        '{ROW_RECORD, 32'hFFFF_FFFD, 1'b0, 29'd0,         6'd0,  29'd0,         32'd0},
        '{ROW_PERIOD, 32'hFFFF_FFFF, 1'b0, 29'd0,         6'd0,  29'd0,         32'd0},
        '{ROW_RECORD, 32'hFFFF_FFFD, 1'b0, 29'd0,         6'd0,  29'd0,         32'd0},
        '{ROW_RECORD, 32'h0000_0001, 1'b1, 29'h1FFF_FFFF, 6'd63, 29'h1FFF_FFFF, 32'd0},
        '{ROW_READ,   32'd63,        1'b0, 29'd0,         6'd0,  29'd0,         32'd0},
        '{ROW_READ,   32'h2A,        1'b0, 29'd0,         6'd0,  29'd0,         32'd0},
        '{ROW_READ,   32'h15,        1'b0, 29'd0,         6'd0,  29'd0,         32'd0}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;     // timestamp[31:0], bin_select[37:32], zero fill
    logic        s_tuser;     // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;     // jitter[28:0], bin[34:29], max_jitter[63:35], bin_count[95:64]

    logic [TIME_W-1:0]  period_model = NOMINAL_RESET;
    logic [TIME_W-1:0]  last_stamp = '0;
    logic [31:0]        peak_model = '0;
    logic [COUNT_W-1:0] bin_tally [BIN_COUNT];
    hist_report_t       reports_due [$];
    int                 mismatch_count = 0;
    int                 holds_asked = 0;
    int                 burst_left = 0;
    bit                 sender_quiet = 1'b0;

    period_jitter_histogram dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic hist_report_t histogram_step(op_t op, logic [31:0] stamp,
                                                    logic [BIN_W-1:0] sel);
        hist_report_t     report;
        logic [31:0]      interval;
        logic [31:0]      deviation;
        logic [31:0]      rounded;
        logic [BIN_W-1:0] slot;
        report = '0;
        if (op == OP_READ) begin
            report.max_jitter = peak_model[JIT_W-1:0];
            if (sel < BIN_COUNT) begin
                report.bin_count = bin_tally[sel];
            end
            return report;
        end
        interval = stamp - last_stamp;
        if (interval > period_model) begin
            deviation = interval - period_model;
        end else begin
            deviation = period_model - interval;
        end
        rounded = (deviation + 32'(ROUND_BIAS)) >> ROUND_SHIFT;
        if (rounded > peak_model) begin
            peak_model = rounded;
        end
        if (rounded >= BIN_COUNT) begin
            slot = BIN_W'(BIN_COUNT - 1);
        end else begin
            slot = rounded[BIN_W-1:0];
        end
        bin_tally[slot] = bin_tally[slot] + 1'b1;
        last_stamp = stamp;
        report.jitter = rounded[JIT_W-1:0];
        report.bin = slot;
        report.max_jitter = peak_model[JIT_W-1:0];
        return report;
    endfunction

    task automatic compare_field(string label, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        hist_report_t seen;
        hist_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata;
            if (reports_due.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, got %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = reports_due.pop_front();
                compare_field("jitter", 32'(want.jitter), 32'(seen.jitter));
                compare_field("bin", 32'(want.bin), 32'(seen.bin));
                compare_field("max_jitter", 32'(want.max_jitter), 32'(seen.max_jitter));
                compare_field("bin_count", want.bin_count, seen.bin_count);
            end
        end
    end

    // Sender bursts: a new burst may start after a random gap with valid low.
    task automatic pace();
        int gap;
        if (sender_quiet) begin
            return;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic offer(op_t op, logic [31:0] stamp, logic [BIN_W-1:0] sel,
                         logic typed, hist_report_t want);
        hist_report_t predicted;
        pace();
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, sel, stamp};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        predicted = histogram_step(op, stamp, sel);
        reports_due.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_period(logic [31:0] period);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= period;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        period_model = period;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : receiver
        int           holds_done;
        int           span;
        stall_style_t style;
        holds_done = 0;
        m_tready = 1'b0;
        forever begin
            style = stall_style_t'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            for (int i = 0; i < span; i++) begin
                @(negedge aclk);
                if (holds_done != holds_asked) begin
                    holds_done++;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge aclk);
                end else begin
                    case (style)
                        FLOW_FREE: m_tready <= 1'b1;
                        FLOW_SPARSE: m_tready <= ($urandom_range(0, 3) != 0);
                        FLOW_DENSE: m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= (i % 3 != 2);
                    endcase
                end
            end
        end
    end

    initial begin : stimulus
        step_row_t    row;
        hist_report_t want;
        logic [31:0]  phase_periods [6];
        int           pick;
        int           skew;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_RECORD;
        for (int b = 0; b < BIN_COUNT; b++) begin
            bin_tally[b] = '0;
        end
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = directed_rows[r];
            want.jitter = row.jitter;
            want.bin = row.bin;
            want.max_jitter = row.max_jitter;
            want.bin_count = row.bin_count;
            case (row.kind)
                ROW_PERIOD: write_period(row.value);
                ROW_READ: offer(OP_READ, $urandom, row.value[BIN_W-1:0], row.typed, want);
                default: offer(OP_RECORD, row.value, BIN_W'($urandom), row.typed, want);
            endcase
        end

        phase_periods[0] = NOMINAL_RESET;
        phase_periods[1] = $urandom;
        phase_periods[2] = 32'd0;
        phase_periods[3] = 32'hFFFF_FFFF;
        phase_periods[4] = 32'($urandom_range(1, 2000));
        phase_periods[5] = $urandom;
        for (int p = 0; p < 6; p++) begin
            write_period(phase_periods[p]);
            sender_quiet = (p == 0 || p == 2);
            if (p == 2) begin
                holds_asked++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                skew = $urandom_range(0, 1200);
                if (pick < 30) begin
                    offer(OP_READ, $urandom, BIN_W'($urandom), 1'b0, '0);
                end else if (pick < 38) begin
                    offer(OP_RECORD, $urandom, BIN_W'($urandom), 1'b0, '0);
                end else begin
                    offer(OP_RECORD, last_stamp + period_model + skew - 32'd600,
                          BIN_W'($urandom), 1'b0, '0);
                end
            end
        end

        drain();
        if (mismatch_count == 0) begin
            $display("period_jitter_histogram_test OK");
        end else begin
            $display("period_jitter_histogram_test NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #(12 * 200000);
        $display("period_jitter_histogram_test NOT OK");
        $finish;
    end

endmodule
